// ===== src/assert_macros.svh =====
// Assertion macros used by the change unit sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define GCU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks that a property holds in the cycle after a trigger.
`define GCU_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/gcu_pkg.sv =====
// Types, constants and codes of the vending change unit.
`default_nettype none

package gcu_pkg;

    localparam int NUM_ITEMS   = 4;
    localparam int NUM_COINS   = 6;
    localparam int CREDIT_BITS = 10;

    // One credit result and one vend result leave room for this many coins per item.
    localparam int MAX_RESULTS = 17;
    localparam int COINS_MAX   = MAX_RESULTS - 2;

    localparam int ITEM_W     = $clog2(NUM_ITEMS);
    localparam int COIN_IDX_W = $clog2(NUM_COINS);
    localparam int COIN_CNT_W = $clog2(COINS_MAX + 1);
    localparam int CHOICE_W   = 4;
    localparam int AMOUNT_W   = 10;
    localparam int KIND_W     = 3;
    localparam int COIN_W     = 7;
    localparam int CFG_IDX_W  = ITEM_W;

    localparam logic [CREDIT_BITS-1:0] CREDIT_MAX = {CREDIT_BITS{1'b1}};

    // Coin denominations, largest first; the smallest one must be 1.
    localparam logic [COIN_W-1:0] DENOMS [NUM_COINS] =
        '{7'd100, 7'd50, 7'd25, 7'd10, 7'd5, 7'd1};

    localparam logic [CREDIT_BITS-1:0] PRICE_DEFAULTS [NUM_ITEMS] =
        '{10'd120, 10'd75, 10'd90, 10'd50};

    localparam logic [CHOICE_W-1:0] CHOICE_FIRST = CHOICE_W'(1);
    localparam logic [CHOICE_W-1:0] CHOICE_LAST  = CHOICE_W'(NUM_ITEMS);
    localparam logic [CHOICE_W-1:0] CHOICE_EXIT  = CHOICE_W'(NUM_ITEMS + 1);

    localparam logic ACT_SELECT = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    localparam logic [KIND_W-1:0] KIND_SELECTED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INVALID  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXIT     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CREDIT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_VEND     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_COIN     = 3'd5;

    typedef logic [NUM_ITEMS-1:0][CREDIT_BITS-1:0] price_array_t;

    typedef enum logic {
        ALU_ADD_SAT = 1'b0,
        ALU_SUB     = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t                op;
        logic [CREDIT_BITS-1:0] a;
        logic [CREDIT_BITS-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [CREDIT_BITS-1:0] result;
        logic                   ge;
    } alu_rsp_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_ADD    = 6'b000100,
        S_CMP    = 6'b001000,
        S_VEND   = 6'b010000,
        S_COIN   = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// ===== src/gcu_if.sv =====
// Handshake channels of the vending change unit: commands, results, configuration.
`default_nettype none

interface gcu_cmd_if;
    import gcu_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [CHOICE_W-1:0]        choice_number;
    logic signed [AMOUNT_W-1:0] amount;
    modport source (output valid, action, choice_number, amount, input ready);
    modport sink   (input valid, action, choice_number, amount, output ready);
endinterface

interface gcu_res_if;
    import gcu_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [ITEM_W-1:0]      item_index;
    logic [COIN_W-1:0]      coin_value;
    logic [CREDIT_BITS-1:0] credit_now;
    logic                   rejected;
    logic                   last_of_run;
    modport source (output valid, kind, item_index, coin_value, credit_now, rejected,
                    last_of_run, input ready);
    modport sink   (input valid, kind, item_index, coin_value, credit_now, rejected,
                    last_of_run, output ready);
endinterface

interface gcu_cfg_if;
    import gcu_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CREDIT_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/vending_controller_greedy_change_unit.sv =====
// Vending controller with greedy change: price registers, sequencer and shared unit.
// A select or an idle insert gives its single result from the decode state once the result
// slot is free. An insert while collecting passes the add and compare states to its credit
// result, then gives the vend result if the credit covers the price, then one result per coin
// (at most 15), skipping too-large denominations, all through one shared add/compare unit.
// Reset (rst_n, asynchronous) sets the block idle with zero credit and default prices.
`default_nettype none

module vending_controller_greedy_change_unit (
    input  wire       clk,
    input  wire       rst_n,
    gcu_cmd_if.sink   cmd,
    gcu_res_if.source res,
    gcu_cfg_if.sink   cfg
);
    import gcu_pkg::*;

    price_array_t price_reg;
    alu_req_t     alu_req;
    alu_rsp_t     alu_rsp;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ITEMS; i++)
            begin
                price_reg[i] <= PRICE_DEFAULTS[i];
            end
        end
        else if (cfg.valid)
        begin
            price_reg[cfg.index] <= cfg.data;
        end
    end

    gcu_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    gcu_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .res     (res),
        .prices  (price_reg),
        .alu_req (alu_req),
        .alu_rsp (alu_rsp)
    );

endmodule

`default_nettype wire

// ===== src/gcu_alu.sv =====
// Shared arithmetic unit: saturating add, or subtract with a greater-or-equal flag.
`default_nettype none

module gcu_alu (
    input  gcu_pkg::alu_req_t req,
    output gcu_pkg::alu_rsp_t rsp
);
    import gcu_pkg::*;

    logic [CREDIT_BITS:0] sum;
    logic [CREDIT_BITS:0] diff;

    always_comb
    begin
        sum    = {1'b0, req.a} + {1'b0, req.b};
        diff   = {1'b0, req.a} - {1'b0, req.b};
        rsp.ge = ~diff[CREDIT_BITS];
        case (req.op)
            ALU_ADD_SAT: rsp.result = sum[CREDIT_BITS] ? CREDIT_MAX : sum[CREDIT_BITS-1:0];
            ALU_SUB:     rsp.result = diff[CREDIT_BITS-1:0];
            default:     rsp.result = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/gcu_ctrl.sv =====
// Sequencer of the change unit: decodes items, drives the shared unit, registers results.
`default_nettype none
`include "assert_macros.svh"

module gcu_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    gcu_cmd_if.sink               cmd,
    gcu_res_if.source             res,
    input  gcu_pkg::price_array_t prices,
    output gcu_pkg::alu_req_t     alu_req,
    input  gcu_pkg::alu_rsp_t     alu_rsp
);
    import gcu_pkg::*;

    state_t                     state_reg, state_next;
    logic                       action_reg, action_next;
    logic [CHOICE_W-1:0]        choice_reg, choice_next;
    logic [AMOUNT_W-1:0]        amount_reg, amount_next;
    logic                       collecting_reg, collecting_next;
    logic [ITEM_W-1:0]          item_reg, item_next;
    logic [CREDIT_BITS-1:0]     credit_reg, credit_next;
    logic [CREDIT_BITS-1:0]     price_due_reg, price_due_next;
    logic [CREDIT_BITS-1:0]     change_reg, change_next;
    logic [COIN_IDX_W-1:0]      coin_idx_reg, coin_idx_next;
    logic [COIN_CNT_W-1:0]      coin_cnt_reg, coin_cnt_next;

    logic                       rvalid_reg, rvalid_next;
    logic [KIND_W-1:0]          kind_reg, kind_next;
    logic [ITEM_W-1:0]          ritem_reg, ritem_next;
    logic [COIN_W-1:0]          coin_reg, coin_next;
    logic [CREDIT_BITS-1:0]     rcredit_reg, rcredit_next;
    logic                       rej_reg, rej_next;
    logic                       last_reg, last_next;

    logic                       slot_free;
    logic                       amount_bad;
    logic [ITEM_W-1:0]          choice_item;
    logic                       coin_last;

    assign cmd.ready       = (state_reg == S_IDLE);
    assign res.valid       = rvalid_reg;
    assign res.kind        = kind_reg;
    assign res.item_index  = ritem_reg;
    assign res.coin_value  = coin_reg;
    assign res.credit_now  = rcredit_reg;
    assign res.rejected    = rej_reg;
    assign res.last_of_run = last_reg;

    assign slot_free   = !rvalid_reg || res.ready;
    assign amount_bad  = (amount_reg == '0) || amount_reg[AMOUNT_W-1];
    assign choice_item = ITEM_W'(choice_reg - CHOICE_FIRST);
    // Dispensing stops when the change is paid out or the coin budget of one item is used up.
    assign coin_last   = (alu_rsp.result == '0)
                         || (coin_cnt_reg == COIN_CNT_W'(COINS_MAX - 1));

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        choice_next     = choice_reg;
        amount_next     = amount_reg;
        collecting_next = collecting_reg;
        item_next       = item_reg;
        credit_next     = credit_reg;
        price_due_next  = price_due_reg;
        change_next     = change_reg;
        coin_idx_next   = coin_idx_reg;
        coin_cnt_next   = coin_cnt_reg;
        rvalid_next     = rvalid_reg && !res.ready;
        kind_next       = kind_reg;
        ritem_next      = ritem_reg;
        coin_next       = coin_reg;
        rcredit_next    = rcredit_reg;
        rej_next        = rej_reg;
        last_next       = last_reg;

        alu_req.op = ALU_ADD_SAT;
        alu_req.a  = credit_reg;
        alu_req.b  = CREDIT_BITS'(amount_reg[AMOUNT_W-2:0]);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    action_next = cmd.action;
                    choice_next = cmd.choice_number;
                    amount_next = cmd.amount;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (action_reg == ACT_INSERT && collecting_reg)
                begin
                    state_next = S_ADD;
                end
                else if (slot_free)
                begin
                    rvalid_next  = 1'b1;
                    kind_next    = KIND_INVALID;
                    ritem_next   = '0;
                    coin_next    = '0;
                    rcredit_next = credit_reg;
                    rej_next     = 1'b0;
                    last_next    = 1'b1;
                    state_next   = S_IDLE;
                    if (action_reg == ACT_INSERT)
                    begin
                        // Money inserted with no item chosen is refused.
                        kind_next = KIND_CREDIT;
                        rej_next  = 1'b1;
                    end
                    else if (!collecting_reg && choice_reg >= CHOICE_FIRST
                             && choice_reg <= CHOICE_LAST)
                    begin
                        item_next       = choice_item;
                        price_due_next  = prices[choice_item];
                        credit_next     = '0;
                        collecting_next = 1'b1;
                        kind_next       = KIND_SELECTED;
                        ritem_next      = choice_item;
                        rcredit_next    = '0;
                    end
                    else if (!collecting_reg && choice_reg == CHOICE_EXIT)
                    begin
                        kind_next = KIND_EXIT;
                    end
                end
            end
            S_ADD:
            begin
                if (!amount_bad)
                begin
                    credit_next = alu_rsp.result;
                end
                state_next = S_CMP;
            end
            S_CMP:
            begin
                alu_req.op = ALU_SUB;
                alu_req.b  = price_due_reg;
                if (slot_free)
                begin
                    rvalid_next  = 1'b1;
                    kind_next    = KIND_CREDIT;
                    ritem_next   = item_reg;
                    coin_next    = '0;
                    rcredit_next = credit_reg;
                    rej_next     = amount_bad;
                    last_next    = !alu_rsp.ge;
                    change_next  = alu_rsp.result;
                    state_next   = alu_rsp.ge ? S_VEND : S_IDLE;
                end
            end
            S_VEND:
            begin
                if (slot_free)
                begin
                    rvalid_next     = 1'b1;
                    kind_next       = KIND_VEND;
                    ritem_next      = item_reg;
                    coin_next       = '0;
                    rcredit_next    = '0;
                    rej_next        = 1'b0;
                    last_next       = (change_reg == '0);
                    credit_next     = '0;
                    collecting_next = 1'b0;
                    coin_idx_next   = '0;
                    coin_cnt_next   = '0;
                    state_next      = (change_reg == '0) ? S_IDLE : S_COIN;
                end
            end
            S_COIN:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = change_reg;
                alu_req.b  = CREDIT_BITS'(DENOMS[coin_idx_reg]);
                if (!alu_rsp.ge)
                begin
                    // This coin is too large for what is left; try the next one.
                    coin_idx_next = coin_idx_reg + 1'b1;
                end
                else if (slot_free)
                begin
                    rvalid_next   = 1'b1;
                    kind_next     = KIND_COIN;
                    ritem_next    = item_reg;
                    coin_next     = DENOMS[coin_idx_reg];
                    rcredit_next  = '0;
                    rej_next      = 1'b0;
                    last_next     = coin_last;
                    change_next   = alu_rsp.result;
                    coin_cnt_next = coin_cnt_reg + 1'b1;
                    if (coin_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            collecting_reg <= 1'b0;
            item_reg       <= '0;
            credit_reg     <= '0;
            price_due_reg  <= '0;
            rvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            collecting_reg <= collecting_next;
            item_reg       <= item_next;
            credit_reg     <= credit_next;
            price_due_reg  <= price_due_next;
            rvalid_reg     <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        choice_reg   <= choice_next;
        amount_reg   <= amount_next;
        change_reg   <= change_next;
        coin_idx_reg <= coin_idx_next;
        coin_cnt_reg <= coin_cnt_next;
        kind_reg     <= kind_next;
        ritem_reg    <= ritem_next;
        coin_reg     <= coin_next;
        rcredit_reg  <= rcredit_next;
        rej_reg      <= rej_next;
        last_reg     <= last_next;
    end

    `GCU_ASSERT_NEXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready,
                     "accepted an item while the previous one was still being decoded")
    `GCU_ASSERT(a_idle_credit_zero, !collecting_reg |-> credit_reg == '0,
                "credit held while no item is selected")
    `GCU_ASSERT(a_coin_after_vend, state_reg == S_COIN |-> !collecting_reg,
                "dispensing change while still collecting")
    `GCU_ASSERT(a_coin_nonzero, rvalid_reg && kind_reg == KIND_COIN |-> coin_reg != '0,
                "coin result without a denomination")

endmodule

`default_nettype wire
